// File: hdl/sjfq_pkg.sv
// ---------------------------------------------------------------------------
// Shortest-job-first queue package
// Shared constants, codes and types for the sorted job queue.
// ---------------------------------------------------------------------------
package sjfq_pkg;

	// Number of cells in the sorted chain.
	localparam int QUEUE_DEPTH = 16;
	// Width of the fill count, which must hold QUEUE_DEPTH itself.
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W = 16;
	localparam int BT_W = 16;

	// Operation codes of an input item.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} opcode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One held job.
	typedef struct packed {
		logic [ID_W-1:0] job_id;
		logic [BT_W-1:0] burst_time;
	} entry_t;

	// Per-cell control from the top level.
	typedef struct packed {
		logic ins;
		logic pop;
		logic occ;
	} cell_ctl_t;

endpackage

// File: hdl/sjfq_in_if.sv
// ---------------------------------------------------------------------------
// Shortest-job-first queue input channel
// Valid/ready channel carrying one insert or pop request.
// ---------------------------------------------------------------------------
interface sjfq_in_if;
	import sjfq_pkg::*;

	logic                  valid;
	logic                  ready;
	opcode_t               opcode;
	logic [ID_W-1:0]       job_id;
	logic [BT_W-1:0]       burst_time;

	modport source (output valid, output opcode, output job_id, output burst_time,
		input ready);
	modport sink (input valid, input opcode, input job_id, input burst_time,
		output ready);

endinterface

// File: hdl/sjfq_out_if.sv
// ---------------------------------------------------------------------------
// Shortest-job-first queue output channel
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface sjfq_out_if;
	import sjfq_pkg::*;

	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [ID_W-1:0]       out_job_id;
	logic [BT_W-1:0]       out_burst_time;
	logic [CNT_W-1:0]      occupancy;

	modport source (output valid, output status, output out_job_id,
		output out_burst_time, output occupancy, input ready);
	modport sink (input valid, input status, input out_job_id,
		input out_burst_time, input occupancy, output ready);

endinterface

// File: hdl/shortest_job_first_queue_top.sv
// Latency: the result of an item is shown in the cycle after its transfer.
// Throughput: one item per cycle while results are taken; the output register
// accepts a new item in the same cycle its held result is taken.
// Each insert or pop is done by the chain of QUEUE_DEPTH cells.
// Reset clears the fill count and output valid; cell contents are not reset.
// ---------------------------------------------------------------------------
// Shortest-job-first queue top level
// Sorted queue of jobs by ascending burst time, built as a chain of cells.
// ---------------------------------------------------------------------------
module shortest_job_first_queue_top (
	input  logic   clk,
	input  logic   arst_n,
	sjfq_in_if.sink    in_ch,
	sjfq_out_if.source out_ch
);
	import sjfq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	status_t          status_q;
	entry_t           res_q;
	logic [CNT_W-1:0] occ_q;

	logic             xfer;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             do_pop;
	entry_t           new_entry;
	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_ge    [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_nxt;
	status_t          status_nxt;

	// A new item is taken whenever the output register is free or drains.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign xfer = in_ch.valid && in_ch.ready;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_ins = xfer && (in_ch.opcode == OP_INSERT) && !full;
	assign do_pop = xfer && (in_ch.opcode == OP_POP) && !empty;

	assign new_entry.job_id     = in_ch.job_id;
	assign new_entry.burst_time = in_ch.burst_time;

	// Chain of cells; cell 0 is the head.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    left_e;
		logic      left_g;
		entry_t    right_e;

		assign ctl.ins = do_ins;
		assign ctl.pop = do_pop;
		assign ctl.occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_e = new_entry;
			assign left_g = 1'b0;
		end else begin : g_body
			assign left_e = cell_entry[i-1];
			assign left_g = cell_ge[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = cell_entry[i];
		end else begin : g_mid
			assign right_e = cell_entry[i+1];
		end

		sjfq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.left_ge     (left_g),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	// Next fill count and status of the current item.
	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
		if (in_ch.opcode == OP_INSERT && full) begin
			status_nxt = ST_FULL;
		end else if (in_ch.opcode == OP_POP && empty) begin
			status_nxt = ST_EMPTY;
		end
	end

	// Control state: fill count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register; the head entry is returned only by a successful pop.
	always_ff @(posedge clk) begin
		if (xfer) begin
			status_q <= status_nxt;
			occ_q    <= count_nxt;
			res_q    <= do_pop ? cell_entry[0] : '0;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.out_job_id     = res_q.job_id;
	assign out_ch.out_burst_time = res_q.burst_time;
	assign out_ch.occupancy      = occ_q;

endmodule

// File: hdl/sjfq_cell.sv
// ---------------------------------------------------------------------------
// Shortest-job-first queue cell
// One slot of the sorted chain: compares its key with the incoming job and
// shifts toward the tail on insert or toward the head on pop.
// ---------------------------------------------------------------------------
module sjfq_cell (
	input  logic               clk,
	input  sjfq_pkg::cell_ctl_t ctl,
	input  sjfq_pkg::entry_t   new_entry,
	input  sjfq_pkg::entry_t   left_entry,
	input  logic               left_ge,
	input  sjfq_pkg::entry_t   right_entry,
	output sjfq_pkg::entry_t   entry,
	output logic               ge
);
	import sjfq_pkg::*;

	entry_t entry_q;

	// The new job belongs at or before this cell when the cell is empty or
	// its key is not below the new key, which puts ties behind the newcomer.
	assign ge = !ctl.occ || (entry_q.burst_time >= new_entry.burst_time);

	// Insert: cells past the slot take their left neighbor, the slot takes
	// the new job. Pop: every cell takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_ge) begin
				entry_q <= left_entry;
			end else if (ge) begin
				entry_q <= new_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

// File: hdl/sjfq_checker.sv
// ---------------------------------------------------------------------------
// Shortest-job-first queue checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module sjfq_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input sjfq_pkg::status_t     status,
	input logic [15:0]           out_job_id,
	input logic [15:0]           out_burst_time,
	input logic [sjfq_pkg::CNT_W-1:0] occupancy
);
	import sjfq_pkg::*;

	// A stalled result holds still until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(out_job_id) && $stable(out_burst_time) && $stable(occupancy))
		else $error("stalled result changed");

	// A rejected insert only happens on a full queue and returns no job.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |->
		occupancy == CNT_W'(QUEUE_DEPTH) && out_job_id == '0 && out_burst_time == '0)
		else $error("full status inconsistent");

	// A rejected pop only happens on an empty queue and returns no job.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |->
		occupancy == '0 && out_job_id == '0 && out_burst_time == '0)
		else $error("empty status inconsistent");

	// The reported fill never exceeds the number of cells.
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy out of range");

endmodule

bind shortest_job_first_queue_top sjfq_checker u_sjfq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.status         (out_ch.status),
	.out_job_id     (out_ch.out_job_id),
	.out_burst_time (out_ch.out_burst_time),
	.occupancy      (out_ch.occupancy)
);
